### rtl/core/brfd_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Shared widths, operation codes and the result word type of the byte ring
// FIFO with delimiter search.
// ----------------------------------------------------------------------------
`default_nettype none

package brfd_pkg;

  localparam int DEPTH_DEFAULT = 4096;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;
  localparam int CAP_W  = 13;
  localparam int OFS_W  = 12;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SKIP = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND = 2'd3;

  localparam int CAPACITY_RESET = 4096;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [CNT_W-1:0]  done_count;
    logic              found;
    logic [OFS_W-1:0]  offset;
    logic [CNT_W-1:0]  fill_level;
    logic              status;
  } brfd_result_t;

endpackage

`default_nettype wire

### rtl/core/brfd_if.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO channels
// Valid/ready channels for operation words, result words and the capacity
// register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface brfd_cmd_if;
  import brfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output op, output data_byte, output count, input ready);
  modport sink (input valid, input op, input data_byte, input count, output ready);
endinterface

interface brfd_rsp_if;
  import brfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  done_count;
  logic              found;
  logic [OFS_W-1:0]  offset;
  logic [CNT_W-1:0]  fill_level;
  logic              status;

  modport source (output valid, output read_byte, output done_count, output found,
                  output offset, output fill_level, output status, input ready);
  modport sink (input valid, input read_byte, input done_count, input found,
                input offset, input fill_level, input status, output ready);
endinterface

interface brfd_cfg_if;
  import brfd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

### rtl/core/brfd_ram.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO storage
// Single-port-write, single-port-read byte memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brfd_ram
  import brfd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [BYTE_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [BYTE_W-1:0]        rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/brfd_out_reg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module brfd_out_reg
  import brfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire brfd_result_t res,
  output logic              free,
  brfd_rsp_if.source        rsp
);

  logic         valid;
  brfd_result_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign free           = !valid || rsp.ready;
  assign rsp.valid      = valid;
  assign rsp.read_byte  = data.read_byte;
  assign rsp.done_count = data.done_count;
  assign rsp.found      = data.found;
  assign rsp.offset     = data.offset;
  assign rsp.fill_level = data.fill_level;
  assign rsp.status     = data.status;

endmodule

`default_nettype wire

### rtl/core/brfd_ctrl.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO control
// Pointer and fill bookkeeping, operation sequencing and the delimiter scan
// over the storage read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brfd_ctrl
  import brfd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  brfd_cmd_if.sink                      cmd,
  brfd_cfg_if.sink                      cfg,
  output logic                          wr_en,
  output logic      [$clog2(DEPTH)-1:0] wr_addr,
  output logic      [BYTE_W-1:0]        wr_data,
  output logic                          rd_en,
  output logic      [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic [BYTE_W-1:0]        rd_data,
  output logic                          res_load,
  output brfd_result_t                  res,
  input  wire logic                     res_free
);

  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = $clog2(DEPTH + 1);
  localparam int CAP_RST = (CAPACITY_RESET > DEPTH) ? DEPTH : CAPACITY_RESET;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state, state_next;
  logic [NW-1:0]     capacity, capacity_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [NW-1:0]     stored, stored_next;
  logic [AW-1:0]     scan_ptr, scan_ptr_next;
  logic [AW-1:0]     scan_idx, scan_idx_next;
  logic [BYTE_W-1:0] delim, delim_next;

  logic          cmd_fire;
  logic          cfg_fire;
  logic          skip_clip;
  logic [NW-1:0] skip_done;
  logic [NW-1:0] stored_less;
  logic          scan_match;
  logic          scan_last;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [NW-1:0] n,
                                             input logic [NW-1:0] cap);
    logic [NW:0] s;
    s = (NW+1)'(p) + (NW+1)'(n);
    if (s >= (NW+1)'(cap)) begin
      s = s - (NW+1)'(cap);
    end
    return s[AW-1:0];
  endfunction

  assign cmd.ready = !rst && (state == ST_IDLE) && res_free && !cfg.valid;
  assign cfg.ready = !rst && (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign skip_clip   = 32'(cmd.count) > 32'(stored);
  assign skip_done   = skip_clip ? stored : NW'(cmd.count);
  assign stored_less = stored - skip_done;
  assign scan_match  = (rd_data == delim);
  assign scan_last   = (NW'(scan_idx) + NW'(1)) == stored;

  always_comb begin
    state_next    = state;
    capacity_next = capacity;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    stored_next   = stored;
    scan_ptr_next = scan_ptr;
    scan_idx_next = scan_idx;
    delim_next    = delim;
    wr_en         = 1'b0;
    wr_addr       = wr_ptr;
    wr_data       = cmd.data_byte;
    rd_en         = 1'b0;
    rd_addr       = rd_ptr;
    res_load      = 1'b0;
    res           = '0;
    res.fill_level = CNT_W'(stored);

    case (state)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg.capacity == '0) begin
            capacity_next = NW'(1);
          end else if (32'(cfg.capacity) > 32'(DEPTH)) begin
            capacity_next = NW'(DEPTH);
          end else begin
            capacity_next = NW'(cfg.capacity);
          end
          stored_next = '0;
          rd_ptr_next = '0;
          wr_ptr_next = '0;
        end else if (cmd_fire) begin
          case (cmd.op)
            OP_PUSH: begin
              res_load = 1'b1;
              if (stored >= capacity) begin
                res.status = 1'b1;
              end else begin
                wr_en           = 1'b1;
                wr_ptr_next     = wrap_add(wr_ptr, NW'(1), capacity);
                stored_next     = stored + NW'(1);
                res.done_count  = CNT_W'(1);
                res.fill_level  = CNT_W'(stored + NW'(1));
              end
            end
            OP_POP: begin
              if (stored == '0) begin
                res_load   = 1'b1;
                res.status = 1'b1;
              end else begin
                rd_en      = 1'b1;
                state_next = ST_POP;
              end
            end
            OP_SKIP: begin
              res_load       = 1'b1;
              res.status     = skip_clip;
              res.done_count = CNT_W'(skip_done);
              res.fill_level = CNT_W'(stored_less);
              if (skip_done != '0) begin
                stored_next = stored_less;
                if (stored_less == '0) begin
                  rd_ptr_next = '0;
                  wr_ptr_next = '0;
                end else begin
                  rd_ptr_next = wrap_add(rd_ptr, skip_done, capacity);
                end
              end
            end
            OP_FIND: begin
              if (stored == '0) begin
                res_load   = 1'b1;
                res.status = 1'b1;
              end else begin
                rd_en         = 1'b1;
                scan_ptr_next = wrap_add(rd_ptr, NW'(1), capacity);
                scan_idx_next = '0;
                delim_next    = cmd.data_byte;
                state_next    = ST_SCAN;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        if (res_free) begin
          res_load       = 1'b1;
          res.read_byte  = rd_data;
          res.done_count = CNT_W'(1);
          res.fill_level = CNT_W'(stored - NW'(1));
          stored_next    = stored - NW'(1);
          if (stored == NW'(1)) begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
          end else begin
            rd_ptr_next = wrap_add(rd_ptr, NW'(1), capacity);
          end
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_match || scan_last) begin
          if (res_free) begin
            res_load   = 1'b1;
            res.found  = scan_match;
            res.offset = scan_match ? OFS_W'(scan_idx) : '0;
            res.status = !scan_match;
            state_next = ST_IDLE;
          end
        end else begin
          rd_en         = 1'b1;
          rd_addr       = scan_ptr;
          scan_ptr_next = wrap_add(scan_ptr, NW'(1), capacity);
          scan_idx_next = scan_idx + AW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= NW'(CAP_RST);
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      stored   <= '0;
    end else begin
      state    <= state_next;
      capacity <= capacity_next;
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      stored   <= stored_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    scan_idx <= scan_idx_next;
    delim    <= delim_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) stored <= capacity)
    else $error("Fill level exceeds capacity.");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    stored == '0 |-> (rd_ptr == '0 && wr_ptr == '0))
    else $error("Empty ring with nonzero pointers.");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (NW'(rd_ptr) < capacity) && (NW'(wr_ptr) < capacity))
    else $error("Pointer outside the ring.");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> NW'(scan_idx) < stored)
    else $error("Scan ran past the stored bytes.");

  a_load_free: assert property (@(posedge clk) disable iff (rst) res_load |-> res_free)
    else $error("Result word overwritten before it was taken.");

endmodule

`default_nettype wire

### rtl/core/byte_ring_fifo_with_delimiter_search_unit.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with delimiter search
// Top level: control sequencer, byte storage and result register.
// ----------------------------------------------------------------------------
// Each command word gives one result word. Push, skip, and pop or find on an
// empty ring are answered from the idle state. A pop waits for its byte, which
// comes from the storage memory's registered read port. A find reads one stored
// byte per cycle through that same port until it meets the delimiter or the
// last stored byte. The result register takes a new result word in the cycle
// that the previous one is taken, so a waiting result word holds off the next
// command word only while the sink is not ready. A capacity write empties the
// ring and takes priority over a command word offered in the same cycle.
`default_nettype none

module byte_ring_fifo_with_delimiter_search_unit
  import brfd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input wire logic   clk,
  input wire logic   rst,
  brfd_cmd_if.sink   cmd,
  brfd_rsp_if.source rsp,
  brfd_cfg_if.sink   cfg
);

  localparam int AW = $clog2(DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              res_load;
  logic              res_free;
  brfd_result_t      res;

  brfd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_load (res_load),
    .res      (res),
    .res_free (res_free)
  );

  brfd_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  brfd_out_reg u_out_reg (
    .clk  (clk),
    .rst  (rst),
    .load (res_load),
    .res  (res),
    .free (res_free),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

### verif/byte_ring_fifo_with_delimiter_search_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte ring FIFO with delimiter search: regression test
// Drives push, pop, skip and find words into the ring and compares every
// result word with a cycle-free prediction of the ring kept in the test.
// Directed cases cover empty and full rings, wrap-around and clipped skips.
// A full-ring pass at a reduced capacity and randomized traffic under several
// capacity settings and idle patterns follow.
// ----------------------------------------------------------------------------

module byte_ring_fifo_with_delimiter_search_unit_test;
  import brfd_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEFAULT;
  localparam int FULL_CAP    = 200;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;

  brfd_cmd_if cmd();
  brfd_rsp_if rsp();
  brfd_cfg_if cfg();

  byte_ring_fifo_with_delimiter_search_unit u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp),
    .cfg (cfg)
  );

  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  int unsigned       head = 0;
  int unsigned       tail = 0;
  int unsigned       fill = 0;
  int unsigned       ring_size = CAPACITY_RESET;
  brfd_result_t      expected_results [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cap_writes = 0;
  int unsigned stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned wrap_ptr(input int unsigned p, input int unsigned n);
    int unsigned s;
    s = p + n;
    if (s >= ring_size) s -= ring_size;
    return s;
  endfunction

  function automatic brfd_result_t ring_operation(input logic [OP_W-1:0] op,
                                                  input logic [BYTE_W-1:0] value,
                                                  input logic [CNT_W-1:0] cnt);
    brfd_result_t r;
    int unsigned  n;
    int unsigned  p;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (fill >= ring_size) begin
          r.status = 1'b1;
        end else begin
          ring_bytes[tail] = value;
          tail = wrap_ptr(tail, 1);
          fill++;
          r.done_count = CNT_W'(1);
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          r.status = 1'b1;
        end else begin
          r.read_byte = ring_bytes[head];
          r.done_count = CNT_W'(1);
          fill--;
          if (fill == 0) begin
            head = 0;
            tail = 0;
          end else begin
            head = wrap_ptr(head, 1);
          end
        end
      end
      OP_SKIP: begin
        n = 32'(cnt);
        if (n > fill) begin
          n = fill;
          r.status = 1'b1;
        end
        if (n > 0) begin
          fill -= n;
          if (fill == 0) begin
            head = 0;
            tail = 0;
          end else begin
            head = wrap_ptr(head, n);
          end
        end
        r.done_count = CNT_W'(n);
      end
      OP_FIND: begin
        r.status = 1'b1;
        p = head;
        for (int unsigned i = 0; i < fill; i++) begin
          if (ring_bytes[p] == value) begin
            r.found = 1'b1;
            r.offset = OFS_W'(i);
            r.status = 1'b0;
            break;
          end
          p = wrap_ptr(p, 1);
        end
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.fill_level = CNT_W'(fill);
    return r;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] value,
                           input logic [CNT_W-1:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.op        <= op;
    cmd.data_byte <= value;
    cmd.count     <= cnt;
    do @(posedge clk); while (!cmd.ready);
    expected_results.push_back(ring_operation(op, value, cnt));
    words_sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    cmd.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg.valid    <= 1'b1;
    cfg.capacity <= value;
    do @(posedge clk); while (!cfg.ready);
    if (value == 0) ring_size = 1;
    else if (value > RING_DEPTH) ring_size = RING_DEPTH;
    else ring_size = 32'(value);
    head = 0;
    tail = 0;
    fill = 0;
    cap_writes++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_word;
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  cnt;
    roll  = $urandom_range(99);
    value = BYTE_W'($urandom_range(255));
    cnt   = CNT_W'($urandom_range(8191));
    if (roll < 40) op = OP_PUSH;
    else if (roll < 65) op = OP_POP;
    else if (roll < 80) op = OP_SKIP;
    else op = OP_FIND;
    if (op == OP_SKIP && $urandom_range(9) != 0) cnt = CNT_W'($urandom_range(fill + 2));
    if (op == OP_FIND && fill > 0 && $urandom_range(1) == 1) begin
      value = ring_bytes[wrap_ptr(head, $urandom_range(fill - 1))];
    end
    send_word(op, value, cnt);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic test_directed;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_word(OP_POP, 8'h00, 13'd0);
    send_word(OP_FIND, 8'h00, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd5);
    send_word(OP_PUSH, 8'h00, 13'd0);
    send_word(OP_PUSH, 8'hFF, 13'd0);
    send_word(OP_PUSH, 8'h5A, 13'd0);
    send_word(OP_FIND, 8'hFF, 13'd0);
    send_word(OP_FIND, 8'h11, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd0);
    send_word(OP_POP, 8'h00, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd8191);
    write_capacity(13'd0);
    send_word(OP_PUSH, 8'hA5, 13'd0);
    send_word(OP_PUSH, 8'h3C, 13'd0);
    send_word(OP_FIND, 8'hA5, 13'd0);
    send_word(OP_POP, 8'h00, 13'd0);
    send_word(OP_POP, 8'h00, 13'd0);
    write_capacity(13'd3);
    send_word(OP_PUSH, 8'h01, 13'd0);
    send_word(OP_PUSH, 8'h02, 13'd0);
    send_word(OP_PUSH, 8'h03, 13'd0);
    send_word(OP_PUSH, 8'h04, 13'd0);
    send_word(OP_POP, 8'h00, 13'd0);
    send_word(OP_PUSH, 8'h80, 13'd0);
    send_word(OP_FIND, 8'h80, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd2);
    send_word(OP_FIND, 8'h80, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd1);
    write_capacity(13'd8191);
    send_word(OP_PUSH, 8'h7E, 13'd0);
    send_word(OP_FIND, 8'h7E, 13'd0);
  endtask

  task automatic test_full_ring;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_capacity(CAP_W'(FULL_CAP));
    for (int i = 0; i < FULL_CAP - 1; i++) begin
      send_word(OP_PUSH, BYTE_W'($urandom_range(1, 254)), 13'd0);
    end
    send_word(OP_PUSH, 8'hFF, 13'd0);
    send_word(OP_PUSH, 8'h00, 13'd0);
    send_word(OP_FIND, 8'hFF, 13'd0);
    send_word(OP_FIND, 8'h00, 13'd0);
    repeat (3) send_word(OP_POP, 8'h00, 13'd0);
    repeat (3) send_word(OP_PUSH, 8'h00, 13'd0);
    send_word(OP_FIND, 8'h00, 13'd0);
    send_word(OP_SKIP, 8'h00, 13'd8191);
    repeat (FULL_CAP / 2) send_word(OP_PUSH, BYTE_W'($urandom_range(255)), 13'd0);
    send_word(OP_SKIP, 8'h00, CNT_W'(FULL_CAP / 2));
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [CAP_W-1:0] cap_a,
                                     input logic [CAP_W-1:0] cap_b,
                                     input logic [CAP_W-1:0] cap_c);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_capacity(cap_a);
    repeat (60) random_word();
    write_capacity(cap_b);
    repeat (60) random_word();
    write_capacity(cap_c);
    repeat (35) random_word();
    wait_drained();
    repeat (30) random_word();
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    brfd_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, fill_level %0d", $time,
                 rsp.fill_level);
      end else begin
        want = expected_results.pop_front();
        words_checked++;
        check_field("read_byte", 16'(want.read_byte), 16'(rsp.read_byte));
        check_field("done_count", 16'(want.done_count), 16'(rsp.done_count));
        check_field("found", 16'(want.found), 16'(rsp.found));
        check_field("offset", 16'(want.offset), 16'(rsp.offset));
        check_field("fill_level", 16'(want.fill_level), 16'(rsp.fill_level));
        check_field("status", 16'(want.status), 16'(rsp.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready) ||
        (expected_results.size() == 0 && !cmd.valid && !cfg.valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cmd.valid     = 1'b0;
    cmd.op        = OP_PUSH;
    cmd.data_byte = '0;
    cmd.count     = '0;
    cfg.valid     = 1'b0;
    cfg.capacity  = '0;
    rst           = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_ring();
    test_random_traffic(27, 75, 13'd1, 13'd5, CAP_W'($urandom_range(2, 40)));
    test_random_traffic(75, 27, 13'd2, 13'd4096, 13'd16);
    test_random_traffic(0, 0, 13'd8191, 13'd3, CAP_W'($urandom_range(1, 300)));

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d operation words and checked %0d result words across %0d capacity writes,",
             words_sent, words_checked, cap_writes);
    $display("covering full and empty rings, wrap-around, clipped skips and delimiter searches.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/brfd_pkg.sv
rtl/core/brfd_if.sv
rtl/core/brfd_ram.sv
rtl/core/brfd_out_reg.sv
rtl/core/brfd_ctrl.sv
rtl/core/byte_ring_fifo_with_delimiter_search_unit.sv
verif/byte_ring_fifo_with_delimiter_search_unit_test.sv
